// ===== rtl/per_sender_packet_reassembler_defines.svh =====
// assertion macros for the per-sender packet reassembler
`ifndef PER_SENDER_PACKET_REASSEMBLER_DEFINES_SVH
`define PER_SENDER_PACKET_REASSEMBLER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define PSR_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define PSR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/psr_pkg.sv =====
// shared constants, codes and types of the per-sender packet reassembler
`default_nettype none

package psr_pkg;

  localparam int unsigned MAX_PACKET_DEF  = 32;
  localparam int unsigned NUM_SENDERS_DEF = 64;
  localparam int unsigned NUM_IDS_DEF     = 64;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SEL_W    = 6;
  localparam int unsigned STATUS_W = 2;

  localparam logic CMD_DEFINE = 1'b0;
  localparam logic CMD_FRAME  = 1'b1;

  localparam logic KIND_DEFINE = 1'b0;
  localparam logic KIND_BYTE   = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IN_USE    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TOO_LARGE = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_EMIT
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/psr_in_if.sv =====
// input word channel of the packet reassembler
`default_nettype none

interface psr_in_if;
  import psr_pkg::*;

  logic              valid;
  logic              ready;
  logic              cmd;
  logic [BYTE_W-1:0] sender;
  logic [BYTE_W-1:0] pkt_tag;
  logic [BYTE_W-1:0] packet_size;
  logic [BYTE_W-1:0] frame_len;
  logic [BYTE_W-1:0] data_byte;
  logic              has_data;
  logic              first_of_frame;
  logic              last_of_frame;

  modport source (
    output valid, cmd, sender, pkt_tag, packet_size, frame_len, data_byte,
           has_data, first_of_frame, last_of_frame,
    input  ready
  );

  modport sink (
    input  valid, cmd, sender, pkt_tag, packet_size, frame_len, data_byte,
           has_data, first_of_frame, last_of_frame,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/psr_out_if.sv =====
// result word channel of the packet reassembler
`default_nettype none

interface psr_out_if;
  import psr_pkg::*;

  logic                valid;
  logic                ready;
  logic                kind;
  logic [STATUS_W-1:0] status;
  logic [SEL_W-1:0]    out_sender;
  logic [BYTE_W-1:0]   out_pkt_tag;
  logic [BYTE_W-1:0]   out_byte;
  logic                last;

  modport source (
    output valid, kind, status, out_sender, out_pkt_tag, out_byte, last,
    input  ready
  );

  modport sink (
    input  valid, kind, status, out_sender, out_pkt_tag, out_byte, last,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/psr_pkt_buf.sv =====
// packet byte buffer: one write port, one registered read port with write-through
`default_nettype none

module psr_pkt_buf #(
  parameter int unsigned DEPTH = 2048,
  parameter int unsigned AW    = 11
) (
  input  logic                      clk,
  input  logic                      wr_en,
  input  logic [AW-1:0]             wr_addr,
  input  logic [psr_pkg::BYTE_W-1:0] wr_data,
  input  logic [AW-1:0]             rd_addr,
  output logic [psr_pkg::BYTE_W-1:0] rd_data
);
  import psr_pkg::*;

  logic [BYTE_W-1:0] buf_mem [DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      buf_mem[wr_addr] <= wr_data;
    end
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= buf_mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/per_sender_packet_reassembler.sv =====
// per-sender packet reassembler top level
//
// Takes one word at a time. The sender's fill count and the ID's size are
// read from their memories as a word is taken; the word then updates them
// and appends its payload byte to the sender's packet buffer. A define word
// gives one result; a frame end that completes a packet of nonzero size then
// streams the packet out of the buffer memory at one byte per cycle while the
// result side takes them, so such a word holds the input until the last byte
// is loaded. The ID and fill tables clear at reset through per-entry valid
// bits, so the block takes words right after reset with no clearing pass.
`default_nettype none

module per_sender_packet_reassembler #(
  parameter int unsigned MAX_PACKET  = psr_pkg::MAX_PACKET_DEF,
  parameter int unsigned NUM_SENDERS = psr_pkg::NUM_SENDERS_DEF,
  parameter int unsigned NUM_IDS     = psr_pkg::NUM_IDS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  psr_in_if.sink    in_ch,
  psr_out_if.source out_ch
);
  import psr_pkg::*;

  localparam int unsigned FW       = $clog2(MAX_PACKET + 1);
  localparam int unsigned SW       = (NUM_SENDERS > 1) ? $clog2(NUM_SENDERS) : 1;
  localparam int unsigned IW       = (NUM_IDS > 1) ? $clog2(NUM_IDS) : 1;
  localparam int unsigned PB_DEPTH = NUM_SENDERS * MAX_PACKET;
  localparam int unsigned PB_AW    = (PB_DEPTH > 1) ? $clog2(PB_DEPTH) : 1;

  function automatic logic [PB_AW-1:0] pb_addr(input logic [SEL_W-1:0] s,
                                               input logic [FW-1:0] k);
    pb_addr = PB_AW'(int'(s) * int'(MAX_PACKET) + int'(k));
  endfunction

  state_t st_r, st_nxt;

  logic                in_fire;
  logic                out_free;
  logic                out_load;

  // captured word
  logic                it_cmd_r;
  logic [SEL_W-1:0]    it_s_r;
  logic [BYTE_W-1:0]   it_pid_r;
  logic [BYTE_W-1:0]   it_psize_r;
  logic [BYTE_W-1:0]   it_flen_r;
  logic [BYTE_W-1:0]   it_dbyte_r;
  logic                it_has_r;
  logic                it_first_r;
  logic                it_last_r;

  logic                dropping_r, dropping_nxt;
  logic [NUM_IDS-1:0]     id_def_r;
  logic [NUM_SENDERS-1:0] fill_vld_r;

  logic [FW-1:0]       id_size_mem [NUM_IDS];
  logic [FW-1:0]       fill_mem [NUM_SENDERS];
  logic [FW-1:0]       id_size_rd_r;
  logic [FW-1:0]       fill_rd_r;
  logic [IW-1:0]       id_raddr;
  logic [SW-1:0]       fill_raddr;
  logic [IW-1:0]       id_idx;
  logic [SW-1:0]       s_idx;
  logic                id_we;
  logic                fill_we;

  logic                pb_we;
  logic [PB_AW-1:0]    pb_waddr;
  logic [PB_AW-1:0]    pb_raddr;
  logic [BYTE_W-1:0]   pb_rdata;

  logic [FW-1:0]       emit_k_r, emit_k_nxt;
  logic [FW-1:0]       emit_size_r, emit_size_nxt;
  logic [FW-1:0]       k_inc;
  logic                last_k;

  // frame datapath
  logic                s_ok;
  logic                id_ok;
  logic                id_known;
  logic [FW-1:0]       fill0, fill1, fill2, fill3;
  logic                ovf;
  logic                drop1;
  logic                app;
  logic                done_ok;
  logic                clear_fill;
  logic                emit_go;
  logic [STATUS_W-1:0] def_stat;

  logic                out_valid_r;
  logic                out_kind_r, out_kind_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic [SEL_W-1:0]    out_sender_r, out_sender_nxt;
  logic [BYTE_W-1:0]   out_pid_r, out_pid_nxt;
  logic [BYTE_W-1:0]   out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;

  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_ch.ready = (st_r == S_IDLE);

  assign id_idx = it_pid_r[IW-1:0];
  assign s_idx  = it_s_r[SW-1:0];

  // read addresses follow the input while idle, the held word otherwise
  assign id_raddr   = (st_r == S_IDLE) ? in_ch.pkt_tag[IW-1:0] : id_idx;
  assign fill_raddr = (st_r == S_IDLE) ? in_ch.sender[SW-1:0] : s_idx;

  assign s_ok     = 7'(it_s_r) < 7'(NUM_SENDERS);
  assign id_ok    = 7'(it_pid_r[SEL_W-1:0]) < 7'(NUM_IDS);
  assign id_known = id_ok && id_def_r[id_idx];

  assign fill0 = fill_vld_r[s_idx] ? fill_rd_r : '0;
  assign ovf   = (9'(fill0) + 9'(it_flen_r)) > 9'(MAX_PACKET);
  assign drop1 = it_first_r ? ovf : dropping_r;
  assign fill1 = (it_first_r && ovf) ? '0 : fill0;
  assign app   = !drop1 && it_has_r && (fill1 < FW'(MAX_PACKET));
  assign fill2 = app ? fill1 + FW'(1) : fill1;

  assign done_ok    = it_last_r && !drop1 && id_known && (fill2 >= id_size_rd_r);
  assign clear_fill = it_last_r && !drop1 && (!id_known || (fill2 >= id_size_rd_r));
  assign fill3      = clear_fill ? '0 : fill2;
  assign emit_go    = done_ok && (id_size_rd_r != '0);

  assign def_stat = (!id_ok || id_def_r[id_idx]) ? ST_IN_USE :
                    (it_psize_r > 8'(MAX_PACKET)) ? ST_TOO_LARGE : ST_OK;

  assign k_inc  = emit_k_r + FW'(1);
  assign last_k = (k_inc == emit_size_r);

  assign pb_waddr = pb_addr(it_s_r, fill1);

  always_comb begin
    st_nxt         = st_r;
    dropping_nxt   = dropping_r;
    out_load       = 1'b0;
    id_we          = 1'b0;
    fill_we        = 1'b0;
    pb_we          = 1'b0;
    pb_raddr       = pb_addr(it_s_r, '0);
    emit_k_nxt     = emit_k_r;
    emit_size_nxt  = emit_size_r;
    out_kind_nxt   = KIND_BYTE;
    out_status_nxt = ST_OK;
    out_sender_nxt = it_s_r;
    out_pid_nxt    = it_pid_r;
    out_byte_nxt   = pb_rdata;
    out_last_nxt   = last_k;
    case (st_r)
      S_IDLE: begin
        if (in_fire) begin
          st_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (it_cmd_r == CMD_DEFINE) begin
          if (out_free) begin
            out_load       = 1'b1;
            out_kind_nxt   = KIND_DEFINE;
            out_status_nxt = def_stat;
            out_sender_nxt = '0;
            out_byte_nxt   = '0;
            out_last_nxt   = 1'b0;
            id_we          = (def_stat == ST_OK);
            st_nxt         = S_IDLE;
          end
        end else if (s_ok) begin
          fill_we      = 1'b1;
          pb_we        = app;
          dropping_nxt = it_last_r ? 1'b0 : drop1;
          if (emit_go) begin
            emit_k_nxt    = '0;
            emit_size_nxt = id_size_rd_r;
            st_nxt        = S_EMIT;
          end else begin
            st_nxt = S_IDLE;
          end
        end else begin
          st_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        pb_raddr = pb_addr(it_s_r, emit_k_r);
        if (out_free) begin
          out_load = 1'b1;
          if (last_k) begin
            st_nxt = S_IDLE;
          end else begin
            emit_k_nxt = k_inc;
            pb_raddr   = pb_addr(it_s_r, k_inc);
          end
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      dropping_r  <= 1'b0;
      id_def_r    <= '0;
      fill_vld_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      dropping_r  <= dropping_nxt;
      out_valid_r <= out_load || (out_valid_r && !out_ch.ready);
      if (id_we) begin
        id_def_r[id_idx] <= 1'b1;
      end
      if (fill_we) begin
        fill_vld_r[s_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      it_cmd_r   <= in_ch.cmd;
      it_s_r     <= in_ch.sender[SEL_W-1:0];
      it_pid_r   <= in_ch.pkt_tag;
      it_psize_r <= in_ch.packet_size;
      it_flen_r  <= in_ch.frame_len;
      it_dbyte_r <= in_ch.data_byte;
      it_has_r   <= in_ch.has_data;
      it_first_r <= in_ch.first_of_frame;
      it_last_r  <= in_ch.last_of_frame;
    end
    emit_k_r    <= emit_k_nxt;
    emit_size_r <= emit_size_nxt;
    if (out_load) begin
      out_kind_r   <= out_kind_nxt;
      out_status_r <= out_status_nxt;
      out_sender_r <= out_sender_nxt;
      out_pid_r    <= out_pid_nxt;
      out_byte_r   <= out_byte_nxt;
      out_last_r   <= out_last_nxt;
    end
  end

  // id size and fill count memories
  always_ff @(posedge clk) begin
    if (id_we) begin
      id_size_mem[id_idx] <= it_psize_r[FW-1:0];
    end
    id_size_rd_r <= id_size_mem[id_raddr];
    if (fill_we) begin
      fill_mem[s_idx] <= fill3;
    end
    fill_rd_r <= fill_mem[fill_raddr];
  end

  psr_pkt_buf #(
    .DEPTH (PB_DEPTH),
    .AW    (PB_AW)
  ) u_pkt_buf (
    .clk     (clk),
    .wr_en   (pb_we),
    .wr_addr (pb_waddr),
    .wr_data (it_dbyte_r),
    .rd_addr (pb_raddr),
    .rd_data (pb_rdata)
  );

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.out_sender  = out_sender_r;
  assign out_ch.out_pkt_tag = out_pid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last        = out_last_r;

`include "per_sender_packet_reassembler_defines.svh"

  `PSR_ASSERT_NEXT(a_accept_exec, in_fire, st_r == S_EXEC, "accepted word not executed")
  `PSR_ASSERT_SAME(a_emit_range, st_r == S_EMIT, emit_k_r < emit_size_r, "readout index past size")
  `PSR_ASSERT_SAME(a_fill_bound, (st_r == S_EXEC) && fill_we, fill3 <= FW'(MAX_PACKET), "fill overrun")
  `PSR_ASSERT_NEXT(a_emit_end, (st_r == S_EMIT) && out_load && last_k, st_r == S_IDLE, "readout did not end")

endmodule

`default_nettype wire

// ===== tb/tb_per_sender_packet_reassembler.sv =====
`timescale 1ns / 1ps
// self-checking testbench of the per-sender packet reassembler: directed and random defines and frames
module tb_per_sender_packet_reassembler;
  import psr_pkg::*;

  localparam int unsigned NUM_WORDS    = 175;
  localparam int unsigned HOLD_AT      = 40;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned QUIET_FROM   = 100;
  localparam int unsigned QUIET_TO     = 160;
  localparam int unsigned IDLE_PCT     = 15;
  localparam int unsigned DRAIN_CYCLES = 60;

  typedef struct packed {
    logic              cmd;
    logic [BYTE_W-1:0] sender;
    logic [BYTE_W-1:0] pkt_tag;
    logic [BYTE_W-1:0] packet_size;
    logic [BYTE_W-1:0] frame_len;
    logic [BYTE_W-1:0] data_byte;
    logic              has_data;
    logic              first_of_frame;
    logic              last_of_frame;
  } frag_word_t;

  typedef struct packed {
    logic                kind;
    logic [STATUS_W-1:0] status;
    logic [SEL_W-1:0]    snd;
    logic [BYTE_W-1:0]   pid;
    logic [BYTE_W-1:0]   data;
    logic                last;
  } pkt_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  always #5 clk = ~clk;

  psr_in_if  in_ch();
  psr_out_if out_ch();

  per_sender_packet_reassembler dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  frag_word_t frag_queue[$];
  pkt_word_t  expected_words[$];

  int unsigned words_in = 0;
  int unsigned defines_in = 0;
  int unsigned results_seen = 0;
  int unsigned packets_done = 0;
  int unsigned mismatches = 0;
  bit          in_fire = 1'b0;
  bit          hold_done = 1'b0;
  int unsigned hold_left = 0;

  // predicted block state
  logic              id_known [NUM_IDS_DEF]     = '{default: 1'b0};
  logic [SEL_W-1:0]  id_len   [NUM_IDS_DEF]     = '{default: '0};
  int unsigned       fill_of  [NUM_SENDERS_DEF] = '{default: 0};
  logic [BYTE_W-1:0] frag_buf [NUM_SENDERS_DEF][MAX_PACKET_DEF];
  logic              drop_frame = 1'b0;

  // stimulus-side view of which ids are defined
  bit          gen_known [NUM_IDS_DEF] = '{default: 1'b0};
  int unsigned gen_len   [NUM_IDS_DEF] = '{default: 0};

  function automatic void predict_reassembly(input frag_word_t w);
    int unsigned id;
    int unsigned snd;
    int unsigned k;
    pkt_word_t   r;
    id = 32'(w.pkt_tag[SEL_W-1:0]);
    snd = 32'(w.sender[SEL_W-1:0]);
    r = '0;
    r.pid = w.pkt_tag;
    if (w.cmd == CMD_DEFINE) begin
      r.kind = KIND_DEFINE;
      if (id >= NUM_IDS_DEF || id_known[id]) begin
        r.status = ST_IN_USE;
      end else if (w.packet_size > MAX_PACKET_DEF) begin
        r.status = ST_TOO_LARGE;
      end else begin
        r.status = ST_OK;
        id_known[id] = 1'b1;
        id_len[id] = w.packet_size[SEL_W-1:0];
      end
      expected_words.push_back(r);
      return;
    end
    if (snd >= NUM_SENDERS_DEF) return;
    if (w.first_of_frame) begin
      if (fill_of[snd] + w.frame_len > MAX_PACKET_DEF) begin
        fill_of[snd] = 0;
        drop_frame = 1'b1;
      end else begin
        drop_frame = 1'b0;
      end
    end
    if (!drop_frame && w.has_data && fill_of[snd] < MAX_PACKET_DEF) begin
      frag_buf[snd][fill_of[snd]] = w.data_byte;
      fill_of[snd]++;
    end
    if (w.last_of_frame) begin
      if (!drop_frame) begin
        if (id >= NUM_IDS_DEF || !id_known[id]) begin
          fill_of[snd] = 0;
        end else if (fill_of[snd] >= id_len[id]) begin
          r.kind = KIND_BYTE;
          r.snd = w.sender[SEL_W-1:0];
          for (k = 0; k < id_len[id] && k < MAX_PACKET_DEF; k++) begin
            r.data = frag_buf[snd][k];
            r.last = (k + 1 == id_len[id]);
            expected_words.push_back(r);
          end
          fill_of[snd] = 0;
        end
      end
      drop_frame = 1'b0;
    end
  endfunction

  task automatic note_mismatch(input string msg);
    mismatches++;
    $display("ERROR at %0t ns, result %0d: %s", $time, results_seen, msg);
  endtask

  task automatic check_result(input pkt_word_t got);
    pkt_word_t want;
    if (expected_words.size() == 0) begin
      note_mismatch($sformatf("unexpected word kind %0d sender %0d pid %02h byte %02h",
                              got.kind, got.snd, got.pid, got.data));
      return;
    end
    want = expected_words.pop_front();
    if (got.kind != want.kind)
      note_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
    if (got.status != want.status)
      note_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
    if (got.snd != want.snd)
      note_mismatch($sformatf("out_sender %0d, expected %0d", got.snd, want.snd));
    if (got.pid != want.pid)
      note_mismatch($sformatf("out_pkt_tag %02h, expected %02h", got.pid, want.pid));
    if (got.data != want.data)
      note_mismatch($sformatf("out_byte %02h, expected %02h", got.data, want.data));
    if (got.last != want.last)
      note_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
  endtask

  task automatic push_word(input logic cmd, input logic [BYTE_W-1:0] snd, pid, psize, flen,
                           dat, input logic has, first, lst);
    frag_queue.push_back('{cmd, snd, pid, psize, flen, dat, has, first, lst});
  endtask

  task automatic queue_define(input logic [BYTE_W-1:0] pid, input logic [BYTE_W-1:0] size);
    int unsigned id;
    id = 32'(pid[SEL_W-1:0]);
    push_word(CMD_DEFINE, 8'($urandom_range(255)), pid, size, 8'($urandom_range(1, 255)),
              8'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)),
              1'($urandom_range(1)));
    if (!gen_known[id] && size <= MAX_PACKET_DEF) begin
      gen_known[id] = 1'b1;
      gen_len[id] = 32'(size);
    end
  endtask

  task automatic queue_frame(input logic [BYTE_W-1:0] snd, pid, flen, input int unsigned nbytes,
                             input bit id_item);
    int unsigned total;
    int unsigned k;
    total = nbytes + id_item;
    if (total == 0) total = 1;
    for (k = 0; k < total; k++)
      push_word(CMD_FRAME, snd, pid, 8'($urandom_range(255)), flen, 8'($urandom_range(255)),
                nbytes != 0 && !(id_item && k == 0), k == 0, k == total - 1);
  endtask

  function automatic bit in_quiet_window();
    return words_in >= QUIET_FROM && words_in < QUIET_TO;
  endfunction

  // sampling of both channels
  always @(posedge clk) begin
    pkt_word_t got;
    in_fire = 1'b0;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        in_fire = 1'b1;
        words_in++;
        if (in_ch.cmd == CMD_DEFINE) defines_in++;
        predict_reassembly('{cmd: in_ch.cmd, sender: in_ch.sender, pkt_tag: in_ch.pkt_tag,
                             packet_size: in_ch.packet_size, frame_len: in_ch.frame_len,
                             data_byte: in_ch.data_byte, has_data: in_ch.has_data,
                             first_of_frame: in_ch.first_of_frame,
                             last_of_frame: in_ch.last_of_frame});
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{kind: out_ch.kind, status: out_ch.status, snd: out_ch.out_sender,
                pid: out_ch.out_pkt_tag, data: out_ch.out_byte, last: out_ch.last};
        check_result(got);
        results_seen++;
        if (got.kind == KIND_BYTE && got.last) packets_done++;
      end
    end
  end

  // word driver
  always @(negedge clk) begin
    frag_word_t w;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_fire) begin
      if (frag_queue.size() != 0 && (in_quiet_window() || $urandom_range(99) >= IDLE_PCT)) begin
        w = frag_queue.pop_front();
        in_ch.valid          <= 1'b1;
        in_ch.cmd            <= w.cmd;
        in_ch.sender         <= w.sender;
        in_ch.pkt_tag        <= w.pkt_tag;
        in_ch.packet_size    <= w.packet_size;
        in_ch.frame_len      <= w.frame_len;
        in_ch.data_byte      <= w.data_byte;
        in_ch.has_data       <= w.has_data;
        in_ch.first_of_frame <= w.first_of_frame;
        in_ch.last_of_frame  <= w.last_of_frame;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // result side, with one long hold-off
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else if (!hold_done && words_in >= HOLD_AT) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= in_quiet_window() || $urandom_range(99) >= IDLE_PCT;
    end
  end

  initial begin
    int unsigned n_directed;
    int unsigned pick;
    int unsigned id;
    int unsigned total;
    int unsigned nfr;
    int unsigned f;
    int unsigned chunk;
    int unsigned flen;
    bit          id_item;
    logic [BYTE_W-1:0] pid;
    logic [BYTE_W-1:0] snd;
    logic [BYTE_W-1:0] size;

    queue_define(8'h00, 8'd4);
    queue_define(8'hC0, 8'd9);
    queue_define(8'h01, 8'd33);
    queue_define(8'h41, 8'd255);
    queue_define(8'h02, 8'd32);
    queue_define(8'h03, 8'd0);
    queue_define(8'h3F, 8'd1);
    queue_define(8'h01, 8'd2);
    queue_frame(8'h05, 8'h80, 8'd5, 4, 1'b1);
    queue_frame(8'hFF, 8'hBF, 8'd2, 1, 1'b0);
    // undefined id, frame too long, zero-size packet
    queue_frame(8'h09, 8'h0A, 8'd2, 2, 1'b0);
    queue_frame(8'h0C, 8'h01, 8'd255, 2, 1'b0);
    queue_frame(8'h0D, 8'h03, 8'd1, 1, 1'b0);
    // words with no frame marks still fill the buffer
    push_word(CMD_FRAME, 8'h0E, 8'h01, 8'h00, 8'h01, 8'h00, 1'b1, 1'b0, 1'b0);
    push_word(CMD_FRAME, 8'h0E, 8'h01, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b0, 1'b0);
    push_word(CMD_FRAME, 8'h0E, 8'h41, 8'h00, 8'h01, 8'h5A, 1'b0, 1'b0, 1'b1);
    queue_frame(8'h10, 8'h01, 8'd1, 1, 1'b0);
    queue_frame(8'h10, 8'h01, 8'd1, 1, 1'b0);
    n_directed = frag_queue.size();

    // full buffer: two bytes past the maximum are discarded
    queue_frame(8'h47, 8'h02, 8'd32, MAX_PACKET_DEF + 2, 1'b0);
    while (frag_queue.size() < NUM_WORDS) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        pick = $urandom_range(99);
        if (pick < 60) size = 8'($urandom_range(1, 8));
        else if (pick < 80) size = 8'($urandom_range(9, MAX_PACKET_DEF));
        else if (pick < 88) size = 8'd0;
        else size = 8'($urandom_range(MAX_PACKET_DEF + 1, 255));
        queue_define(8'($urandom_range(255)), size);
      end else if (pick < 75) begin
        id = $urandom_range(NUM_IDS_DEF - 1);
        if ($urandom_range(99) < 85)
          for (f = 0; f < NUM_IDS_DEF && !gen_known[id]; f++) id = (id + 1) % NUM_IDS_DEF;
        pid = 8'($urandom_range(3) * 64 + id);
        snd = 8'($urandom_range(255));
        total = gen_known[id] ? gen_len[id] : $urandom_range(1, 6);
        pick = $urandom_range(99);
        if (pick < 12) total += $urandom_range(1, 3);
        else if (pick < 24 && total > 0) total--;
        nfr = $urandom_range(1, 3);
        for (f = 0; f < nfr; f++) begin
          chunk = (f == nfr - 1) ? total : $urandom_range(0, total);
          total -= chunk;
          id_item = ($urandom_range(3) == 0);
          flen = chunk + id_item + (($urandom_range(9) == 0) ? $urandom_range(1, 40) : 0);
          if (flen == 0) flen = 1;
          if (flen > 255) flen = 255;
          queue_frame(snd, pid, 8'(flen), chunk, id_item);
        end
      end else begin
        push_word(($urandom_range(4) == 0) ? CMD_DEFINE : CMD_FRAME, 8'($urandom_range(255)),
                  8'($urandom_range(255)), 8'($urandom_range(255)),
                  8'($urandom_range(1, 255)), 8'($urandom_range(255)),
                  1'($urandom_range(1)), 1'($urandom_range(1)), 1'($urandom_range(1)));
      end
    end

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    while (frag_queue.size() != 0 || in_ch.valid || expected_words.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d words (%0d defines, %0d directed), checked %0d result words",
             words_in, defines_in, n_directed, results_seen);
    $display("rebuilt %0d packets, result side held off %0d cycles once, %0d mismatches",
             packets_done, HOLD_CYCLES, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("timeout with %0d words still expected", expected_words.size());
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ===== per_sender_packet_reassembler.f =====
+incdir+rtl
rtl/psr_pkg.sv
rtl/psr_in_if.sv
rtl/psr_out_if.sv
rtl/psr_pkt_buf.sv
rtl/per_sender_packet_reassembler.sv
tb/tb_per_sender_packet_reassembler.sv
